// File: rtl/core/deq_pkg.sv
`default_nettype none

package deq_pkg;

    // Width of one stored element
    localparam int unsigned WORD_W = 32;

    // Value reported for a missing element
    localparam logic signed [WORD_W-1:0] INT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LOAD = 1'b1
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/deq_ram.sv
`default_nettype none

module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_operation, i_value_in
// result    out        o_out_valid / i_out_ready o_popped_value, o_status, o_front_value,
//                                                o_rear_value, o_is_empty, o_occupancy
//
// Each transaction goes from idle to load: the accept cycle updates the pointers and
// writes or reads the slot RAM, and the load state takes the registered RAM read data
// into the cached end value and the result register once the result register is free.
// Front and rear values are cached in registers so a pop needs at most one RAM read.
// Reset clears state, pointers, count, refill flags and output valid; slot contents stay undefined.
// A full result register that is not taken holds the load state.

module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_operation,
    input  wire logic signed [deq_pkg::WORD_W-1:0]   i_value_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [deq_pkg::WORD_W-1:0]        o_popped_value,
    output logic [1:0]                               o_status,
    output logic signed [deq_pkg::WORD_W-1:0]        o_front_value,
    output logic signed [deq_pkg::WORD_W-1:0]        o_rear_value,
    output logic                                     o_is_empty,
    output logic [$clog2(DEPTH+1)-1:0]               o_occupancy
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    deq_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_front_idx, n_front_idx;
    logic [CW-1:0]   r_count, n_count;
    logic            r_fill_front, n_fill_front;
    logic            r_fill_rear, n_fill_rear;
    logic            r_out_valid, n_out_valid;

    logic signed [deq_pkg::WORD_W-1:0] r_front_val, n_front_val;
    logic signed [deq_pkg::WORD_W-1:0] r_rear_val, n_rear_val;
    logic signed [deq_pkg::WORD_W-1:0] r_pend_popped, n_pend_popped;
    deq_pkg::t_status                  r_pend_status, n_pend_status;

    logic signed [deq_pkg::WORD_W-1:0] r_out_popped, n_out_popped;
    deq_pkg::t_status                  r_out_status, n_out_status;
    logic signed [deq_pkg::WORD_W-1:0] r_out_front, n_out_front;
    logic signed [deq_pkg::WORD_W-1:0] r_out_rear, n_out_rear;
    logic                              r_out_empty, n_out_empty;
    logic [CW-1:0]                     r_out_count, n_out_count;

    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    logic                        ram_re;
    logic [IW-1:0]               ram_raddr;
    logic [deq_pkg::WORD_W-1:0]  ram_rdata;

    logic [SW-1:0] tail_sum;
    logic [IW-1:0] tail_idx;
    logic [IW-1:0] rear_idx;
    logic [IW-1:0] rear_prev;
    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic          is_full;
    logic          is_none;
    logic          load_ok;

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Ring positions around the current front
    always_comb begin
        tail_sum = SW'(r_front_idx) + SW'(r_count);
        if (tail_sum >= SW'(DEPTH)) begin
            tail_sum = tail_sum - SW'(DEPTH);
        end
        tail_idx  = tail_sum[IW-1:0];
        rear_idx  = (tail_idx == '0) ? IW'(DEPTH - 1) : tail_idx - IW'(1);
        rear_prev = (rear_idx == '0) ? IW'(DEPTH - 1) : rear_idx - IW'(1);
        front_dec = (r_front_idx == '0) ? IW'(DEPTH - 1) : r_front_idx - IW'(1);
        front_inc = (r_front_idx == IW'(DEPTH - 1)) ? '0 : r_front_idx + IW'(1);
        is_full   = (r_count == CW'(DEPTH));
        is_none   = (r_count == '0);
        load_ok   = !r_out_valid || i_out_ready;
    end

    assign o_in_ready = (r_state == deq_pkg::S_IDLE);

    // Next state, pointer update and RAM access
    always_comb begin
        n_state       = r_state;
        n_front_idx   = r_front_idx;
        n_count       = r_count;
        n_fill_front  = r_fill_front;
        n_fill_rear   = r_fill_rear;
        n_front_val   = r_front_val;
        n_rear_val    = r_rear_val;
        n_pend_popped = r_pend_popped;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_popped  = r_out_popped;
        n_out_status  = r_out_status;
        n_out_front   = r_out_front;
        n_out_rear    = r_out_rear;
        n_out_empty   = r_out_empty;
        n_out_count   = r_out_count;
        ram_we        = 1'b0;
        ram_waddr     = tail_idx;
        ram_re        = 1'b0;
        ram_raddr     = front_inc;

        unique case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state       = deq_pkg::S_LOAD;
                    n_fill_front  = 1'b0;
                    n_fill_rear   = 1'b0;
                    n_pend_popped = deq_pkg::INT_MIN;
                    n_pend_status = deq_pkg::ST_DONE;
                    unique case (deq_pkg::t_op'(i_operation))
                        deq_pkg::OP_PUSH_FRONT: begin
                            if (is_full) begin
                                n_pend_status = deq_pkg::ST_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = front_dec;
                                n_front_idx = front_dec;
                                n_count     = r_count + CW'(1);
                                n_front_val = i_value_in;
                                if (is_none) begin
                                    n_rear_val = i_value_in;
                                end
                            end
                        end
                        deq_pkg::OP_PUSH_REAR: begin
                            if (is_full) begin
                                n_pend_status = deq_pkg::ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = tail_idx;
                                n_count    = r_count + CW'(1);
                                n_rear_val = i_value_in;
                                if (is_none) begin
                                    n_front_val = i_value_in;
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT: begin
                            if (is_none) begin
                                n_pend_status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_pend_popped = r_front_val;
                                n_front_idx   = front_inc;
                                n_count       = r_count - CW'(1);
                                // Refill the front cache from the next slot
                                if (r_count > CW'(1)) begin
                                    ram_re       = 1'b1;
                                    ram_raddr    = front_inc;
                                    n_fill_front = 1'b1;
                                end
                            end
                        end
                        deq_pkg::OP_POP_REAR: begin
                            if (is_none) begin
                                n_pend_status = deq_pkg::ST_EMPTY;
                            end else begin
                                n_pend_popped = r_rear_val;
                                n_count       = r_count - CW'(1);
                                // Refill the rear cache from the slot before it
                                if (r_count > CW'(1)) begin
                                    ram_re      = 1'b1;
                                    ram_raddr   = rear_prev;
                                    n_fill_rear = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            deq_pkg::S_LOAD: begin
                // Hold while the result register is still occupied
                if (load_ok) begin
                    n_state      = deq_pkg::S_IDLE;
                    n_fill_front = 1'b0;
                    n_fill_rear  = 1'b0;
                    if (r_fill_front) begin
                        n_front_val = ram_rdata;
                    end
                    if (r_fill_rear) begin
                        n_rear_val = ram_rdata;
                    end
                    n_out_valid  = 1'b1;
                    n_out_popped = r_pend_popped;
                    n_out_status = r_pend_status;
                    n_out_empty  = is_none;
                    n_out_count  = r_count;
                    n_out_front  = is_none ? deq_pkg::INT_MIN : n_front_val;
                    n_out_rear   = is_none ? deq_pkg::INT_MIN : n_rear_val;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= deq_pkg::S_IDLE;
            r_front_idx  <= '0;
            r_count      <= '0;
            r_fill_front <= 1'b0;
            r_fill_rear  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_front_idx  <= n_front_idx;
            r_count      <= n_count;
            r_fill_front <= n_fill_front;
            r_fill_rear  <= n_fill_rear;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_front_val   <= n_front_val;
        r_rear_val    <= n_rear_val;
        r_pend_popped <= n_pend_popped;
        r_pend_status <= n_pend_status;
        r_out_popped  <= n_out_popped;
        r_out_status  <= n_out_status;
        r_out_front   <= n_out_front;
        r_out_rear    <= n_out_rear;
        r_out_empty   <= n_out_empty;
        r_out_count   <= n_out_count;
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_out_popped;
    assign o_status       = r_out_status;
    assign o_front_value  = r_out_front;
    assign o_rear_value   = r_out_rear;
    assign o_is_empty     = r_out_empty;
    assign o_occupancy    = r_out_count;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above depth");

    a_one_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fill_front && r_fill_rear))
        else $error("both end caches marked for refill");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == deq_pkg::S_LOAD))
        else $error("accepted transaction did not reach the load cycle");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_occupancy == '0)))
        else $error("empty flag disagrees with occupancy");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 250000;
    localparam int CALM_TAIL   = 120;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        deq_pkg::t_op                       op;
        logic signed [deq_pkg::WORD_W-1:0]  value;
        bit                                 drain_first;
    } t_deque_op;

    typedef struct {
        logic signed [deq_pkg::WORD_W-1:0]  popped;
        deq_pkg::t_status                   status;
        logic signed [deq_pkg::WORD_W-1:0]  front;
        logic signed [deq_pkg::WORD_W-1:0]  rear;
        logic                               empty;
        logic [4:0]                         occupancy;
    } t_deque_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                               in_valid  = 1'b0;
    deq_pkg::t_op                       in_op     = deq_pkg::OP_PUSH_FRONT;
    logic signed [deq_pkg::WORD_W-1:0]  in_value  = '0;
    logic                               out_ready = 1'b0;

    logic                               o_in_ready;
    logic                               o_out_valid;
    logic signed [deq_pkg::WORD_W-1:0]  o_popped_value;
    logic [1:0]                         o_status;
    logic signed [deq_pkg::WORD_W-1:0]  o_front_value;
    logic signed [deq_pkg::WORD_W-1:0]  o_rear_value;
    logic                               o_is_empty;
    logic [4:0]                         o_occupancy;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (in_op),
        .i_value_in     (in_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_front_value  (o_front_value),
        .o_rear_value   (o_rear_value),
        .o_is_empty     (o_is_empty),
        .o_occupancy    (o_occupancy)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_deque_op     op_backlog[$];
    t_deque_result predicted_results[$];
    int            total_ops      = 0;
    int            accepted_ops   = 0;
    int            error_count    = 0;
    int            cycle_count    = 0;
    int            send_gap       = 0;
    int            recv_stall     = 0;

    // Shadow copy of the ring buffer
    logic signed [deq_pkg::WORD_W-1:0] shadow_slots [DEPTH];
    logic [3:0]                        shadow_head  = '0;
    logic [4:0]                        shadow_count = '0;

    // Idling stops once only the tail of the backlog is left
    function automatic bit calm();
        return (op_backlog.size() < CALM_TAIL);
    endfunction

    function automatic t_deque_result deque_apply(deq_pkg::t_op op,
                                                  logic signed [deq_pkg::WORD_W-1:0] val);
        t_deque_result r;
        logic [3:0]    pos;
        r.popped = deq_pkg::INT_MIN;
        r.status = deq_pkg::ST_DONE;
        case (op)
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
                if (shadow_count == DEPTH) begin
                    r.status = deq_pkg::ST_FULL;
                end else if (op == deq_pkg::OP_PUSH_FRONT) begin
                    shadow_head = shadow_head - 4'd1;
                    shadow_slots[shadow_head] = val;
                    shadow_count++;
                end else begin
                    pos = shadow_head + shadow_count[3:0];
                    shadow_slots[pos] = val;
                    shadow_count++;
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    r.status = deq_pkg::ST_EMPTY;
                end else if (op == deq_pkg::OP_POP_FRONT) begin
                    r.popped = shadow_slots[shadow_head];
                    shadow_head = shadow_head + 4'd1;
                    shadow_count--;
                end else begin
                    pos = shadow_head + shadow_count[3:0] - 4'd1;
                    r.popped = shadow_slots[pos];
                    shadow_count--;
                end
            end
        endcase
        // Report both ends after the step
        if (shadow_count == 0) begin
            r.front = deq_pkg::INT_MIN;
            r.rear  = deq_pkg::INT_MIN;
            r.empty = 1'b1;
        end else begin
            pos     = shadow_head + shadow_count[3:0] - 4'd1;
            r.front = shadow_slots[shadow_head];
            r.rear  = shadow_slots[pos];
            r.empty = 1'b0;
        end
        r.occupancy = shadow_count;
        return r;
    endfunction

    task automatic queue_op(deq_pkg::t_op op, logic signed [deq_pkg::WORD_W-1:0] val,
                            bit drain);
        t_deque_op item;
        item.op          = op;
        item.value       = val;
        item.drain_first = drain;
        op_backlog.push_back(item);
        total_ops++;
    endtask

    function automatic logic signed [deq_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return deq_pkg::INT_MIN;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Driver: predict on each accepted transaction, then offer the next one
    always @(posedge i_clk) begin
        t_deque_op nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predicted_results.push_back(deque_apply(in_op, in_value));
                accepted_ops++;
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (op_backlog.size() != 0 &&
                             !(op_backlog[0].drain_first &&
                               predicted_results.size() != 0)) begin
                    nxt = op_backlog.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= nxt.op;
                    in_value <= nxt.value;
                    if (!calm() && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 11);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_deque_result exp;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (predicted_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: popped=%h status=%0d occupancy=%0d",
                                 o_popped_value, o_status, o_occupancy);
                end else begin
                    exp = predicted_results.pop_front();
                    if (o_popped_value !== exp.popped || o_status !== exp.status ||
                        o_front_value !== exp.front || o_rear_value !== exp.rear ||
                        o_is_empty !== exp.empty || o_occupancy !== exp.occupancy) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display({"mismatch: exp popped=%h status=%0d front=%h ",
                                      "rear=%h empty=%b occ=%0d"},
                                     exp.popped, exp.status, exp.front, exp.rear,
                                     exp.empty, exp.occupancy);
                            $display({"          got popped=%h status=%0d front=%h ",
                                      "rear=%h empty=%b occ=%0d"},
                                     o_popped_value, o_status, o_front_value,
                                     o_rear_value, o_is_empty, o_occupancy);
                        end
                    end
                end
            end
            // Stall the result channel in random bursts
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!calm() && $urandom_range(0, 6) == 0)
                    recv_stall = $urandom_range(1, 11);
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        int run_len;
        int push_pct;
        bit is_push;
        bit drain;

        // Empty pops, then single-element pops from either end
        queue_op(deq_pkg::OP_POP_FRONT, pick_value(), 1'b0);
        queue_op(deq_pkg::OP_POP_REAR, pick_value(), 1'b0);
        queue_op(deq_pkg::OP_PUSH_FRONT, deq_pkg::INT_MIN, 1'b0);
        queue_op(deq_pkg::OP_POP_REAR, 32'sd0, 1'b0);
        queue_op(deq_pkg::OP_PUSH_REAR, 32'sh7FFF_FFFF, 1'b0);
        queue_op(deq_pkg::OP_POP_FRONT, 32'sd0, 1'b0);
        // Fill from both ends, then push into a full deque
        for (int k = 0; k < DEPTH; k++)
            queue_op((k % 2) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT,
                     (k % 4 == 0) ? 32'sh5555_5555 : (k % 4 == 1) ? 32'shAAAA_AAAA :
                     (k % 4 == 2) ? -32'sd1 : deq_pkg::INT_MIN, 1'b0);
        queue_op(deq_pkg::OP_PUSH_FRONT, 32'sd1, 1'b0);
        queue_op(deq_pkg::OP_PUSH_REAR, 32'sd2, 1'b0);

        // Random runs biased toward filling, churning or draining
        while (total_ops < 1300) begin
            run_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            for (int k = 0; k < run_len; k++) begin
                is_push = ($urandom_range(0, 99) < push_pct);
                drain   = (total_ops == 300 || total_ops == 900);
                if (is_push)
                    queue_op($urandom_range(0, 1) ? deq_pkg::OP_PUSH_REAR
                                                  : deq_pkg::OP_PUSH_FRONT,
                             pick_value(), drain);
                else
                    queue_op($urandom_range(0, 1) ? deq_pkg::OP_POP_REAR
                                                  : deq_pkg::OP_POP_FRONT,
                             pick_value(), drain);
            end
        end

        // Hold reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_ops != total_ops)
            @(posedge i_clk);
        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0 && predicted_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue.sv
tb/sv/tb_top.sv
